@@ rtl/texture_coordinate_projector_unit_assert.svh @@
// Assertion macros for the texture coordinate projector.
// Included by the top level; uses its clock and reset ports by name.
`ifndef TEXTURE_COORDINATE_PROJECTOR_UNIT_ASSERT_SVH
`define TEXTURE_COORDINATE_PROJECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define TCPU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define TCPU_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tcp_pkg.sv @@
// Shared types, constants and helper functions for the texture coordinate projector.
// No dependencies; used by texture_coordinate_projector_unit.
`default_nettype none

package tcp_pkg;

   // Defaults for the top-level parameters.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 16;

   // Arctangent table depth and entry width (units of 2^-32 turn).
   localparam int ATAN_ENTRIES = 30;
   localparam int ATAN_W       = 30;
   localparam int ATAN_IDX_W   = 5;

   // Datapath widths.
   localparam int SUM_W   = 33;  // position plus offset, exact
   localparam int XY_W    = 35;  // CORDIC vector, covers the gain of about 1.65
   localparam int Z_W     = 34;  // angle accumulator, 2^-32 turn units
   localparam int PROD_W  = 65;  // 33 x 32 signed product
   localparam int SHIFT_W = 66;  // product with room for negation

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X = 3'd0,
      CSR_OFFSET_Y = 3'd1,
      CSR_SCALE_U  = 3'd2,
      CSR_SCALE_V  = 3'd3,
      CSR_MODE     = 3'd4
   } csr_index_type;

   // Projection mode codes; the other two codes are unsupported.
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_FRONT       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CYLINDRICAL = 2'd1;

   // Reset value of both scales: 1.0 in Q16.16.
   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

   // Saturation bounds of the 32-bit result at the shifter width.
   localparam logic signed [SHIFT_W-1:0] SAT_MAX = {{(SHIFT_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [SHIFT_W-1:0] SAT_MIN = {{(SHIFT_W-31){1'b1}}, {31{1'b0}}};

   // Per-item side information that travels beside the CORDIC vector.
   typedef struct packed {
      logic             ok;      // mode is front or cylindrical
      logic             cyl;     // cylindrical mode
      logic             origin;  // x and y both zero
      logic [SUM_W-1:0] opnd_u;  // operand of the u multiply
      logic [SUM_W-1:0] opnd_v;  // operand of the v multiply
   } side_type;

   // atan(2^-i) / (2 pi), in units of 2^-32 turn.
   function automatic logic [ATAN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      unique case (idx)
         5'd0:    val = 30'd536870912;
         5'd1:    val = 30'd316933406;
         5'd2:    val = 30'd167458907;
         5'd3:    val = 30'd85004756;
         5'd4:    val = 30'd42667331;
         5'd5:    val = 30'd21354465;
         5'd6:    val = 30'd10679838;
         5'd7:    val = 30'd5340245;
         5'd8:    val = 30'd2670163;
         5'd9:    val = 30'd1335087;
         5'd10:   val = 30'd667544;
         5'd11:   val = 30'd333772;
         5'd12:   val = 30'd166886;
         5'd13:   val = 30'd83443;
         5'd14:   val = 30'd41722;
         5'd15:   val = 30'd20861;
         5'd16:   val = 30'd10430;
         5'd17:   val = 30'd5215;
         5'd18:   val = 30'd2608;
         5'd19:   val = 30'd1304;
         5'd20:   val = 30'd652;
         5'd21:   val = 30'd326;
         5'd22:   val = 30'd163;
         5'd23:   val = 30'd81;
         5'd24:   val = 30'd41;
         5'd25:   val = 30'd20;
         5'd26:   val = 30'd10;
         5'd27:   val = 30'd5;
         5'd28:   val = 30'd3;
         5'd29:   val = 30'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Clamp a scaled product to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [SHIFT_W-1:0] q);
      logic [31:0] res;
      priority if (q > SAT_MAX) begin
         res = 32'h7FFF_FFFF;
      end else if (q < SAT_MIN) begin
         res = 32'h8000_0000;
      end else begin
         res = q[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/texture_coordinate_projector_unit.sv @@
// Texture coordinate projector top level: front and cylindrical UV projection pipeline.
// Depends on tcp_pkg and texture_coordinate_projector_unit_assert.svh.
`default_nettype none

// One vertex beat in, one texture coordinate beat out, one beat per cycle while no held
// result stalls the pipeline. The stages are an entry stage that offsets and folds the
// vector into the right half plane, one stage per unrolled CORDIC step (steps above 30
// count as 30), an angle rounding stage, a multiply stage and the saturating output
// register. The whole pipeline moves together, so req_stall rises only while a finished
// result sits in the output register and rsp_stall holds it. Offsets, scales and mode are
// sampled as the items pass, so they must be written only while nothing is in flight.
// Front mode gives u = (x + offset_x) * scale_u, cylindrical mode gives u = atan2(x, -y)
// in turns times scale_u, both give v = -(z + offset_y) * scale_v, all saturated; modes 2
// and 3 return zeros with rsp_valid_res low.
module texture_coordinate_projector_unit #(
   parameter int CORDIC_STEPS = tcp_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = tcp_pkg::FRAC_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   // Vertex input channel.
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire signed [31:0]                  req_pos_x,
   input  wire signed [31:0]                  req_pos_y,
   input  wire signed [31:0]                  req_pos_z,
   // Texture coordinate result channel.
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [31:0]                 rsp_tex_u,
   output logic signed [31:0]                 rsp_tex_v,
   output logic                               rsp_valid_res,
   // Configuration write channel.
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [tcp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [31:0]                         csr_wdata
);

`include "texture_coordinate_projector_unit_assert.svh"

   localparam int SUM_W   = tcp_pkg::SUM_W;
   localparam int XY_W    = tcp_pkg::XY_W;
   localparam int Z_W     = tcp_pkg::Z_W;
   localparam int PROD_W  = tcp_pkg::PROD_W;
   localparam int SHIFT_W = tcp_pkg::SHIFT_W;

   localparam int N_STEPS = (CORDIC_STEPS < tcp_pkg::ATAN_ENTRIES) ?
                            CORDIC_STEPS : tcp_pkg::ATAN_ENTRIES;
   localparam int ST_ANG  = N_STEPS + 1;
   localparam int ST_MUL  = N_STEPS + 2;
   localparam int ST_OUT  = N_STEPS + 3;
   localparam int N_ST    = N_STEPS + 4;
   localparam int ZSH     = 32 - FRAC_BITS;

   // Half turn and the half-unit rounding term for the final angle.
   localparam logic signed [Z_W-1:0] Z_HALF = {{(Z_W-32){1'b0}}, 1'b1, 31'b0};
   localparam logic signed [Z_W-1:0] Z_RND  = Z_W'(64'd1 << (31 - FRAC_BITS));

   // Configuration registers.
   logic signed [31:0]               offset_x_ff;
   logic signed [31:0]               offset_y_ff;
   logic signed [31:0]               scale_u_ff;
   logic signed [31:0]               scale_v_ff;
   logic [tcp_pkg::MODE_W-1:0]       mode_ff;

   // Pipeline control.
   logic [N_ST-1:0]                  vld_ff;
   logic [N_ST-1:0]                  vld_in;
   logic                             adv;

   // Entry and CORDIC stages.
   logic signed [XY_W-1:0]           cx_ff [0:N_STEPS];
   logic signed [XY_W-1:0]           cy_ff [0:N_STEPS];
   logic signed [Z_W-1:0]            cz_ff [0:N_STEPS];
   logic signed [XY_W-1:0]           cx_in [0:N_STEPS];
   logic signed [XY_W-1:0]           cy_in [0:N_STEPS];
   logic signed [Z_W-1:0]            cz_in [0:N_STEPS];
   tcp_pkg::side_type                side_ff [0:ST_ANG];
   tcp_pkg::side_type                side_in [0:ST_ANG];

   // Entry stage helpers.
   logic signed [SUM_W-1:0]          neg_y;
   logic signed [SUM_W-1:0]          pos_x_ext;

   // Angle stage helpers.
   logic signed [Z_W-1:0]            z_rnd;
   logic signed [Z_W-1:0]            ang;

   // Multiply stage.
   logic signed [PROD_W-1:0]         prod_u_ff;
   logic signed [PROD_W-1:0]         prod_v_ff;
   logic signed [PROD_W-1:0]         prod_u_in;
   logic signed [PROD_W-1:0]         prod_v_in;
   logic                             ok_mul_ff;

   // Output register.
   logic signed [SHIFT_W-1:0]        q_u;
   logic signed [SHIFT_W-1:0]        q_v;
   logic [31:0]                      tex_u_ff;
   logic [31:0]                      tex_v_ff;
   logic [31:0]                      tex_u_in;
   logic [31:0]                      tex_v_in;
   logic                             res_ok_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         scale_u_ff  <= tcp_pkg::SCALE_RESET;
         scale_v_ff  <= tcp_pkg::SCALE_RESET;
         mode_ff     <= tcp_pkg::MODE_FRONT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcp_pkg::CSR_OFFSET_X: offset_x_ff <= csr_wdata;
            tcp_pkg::CSR_OFFSET_Y: offset_y_ff <= csr_wdata;
            tcp_pkg::CSR_SCALE_U:  scale_u_ff  <= csr_wdata;
            tcp_pkg::CSR_SCALE_V:  scale_v_ff  <= csr_wdata;
            tcp_pkg::CSR_MODE:     mode_ff     <= csr_wdata[tcp_pkg::MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves as one; only a held result in the output register stops it.
   assign adv       = !(vld_ff[ST_OUT] && rsp_stall);
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[N_ST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Entry stage: offsets, and the vector (-y, x) folded into the right half plane.
   always_comb begin
      neg_y     = -SUM_W'(req_pos_y);
      pos_x_ext = SUM_W'(req_pos_x);
      if (neg_y[SUM_W-1]) begin
         cx_in[0] = XY_W'(-neg_y);
         cy_in[0] = XY_W'(-pos_x_ext);
         cz_in[0] = req_pos_x[31] ? -Z_HALF : Z_HALF;
      end else begin
         cx_in[0] = XY_W'(neg_y);
         cy_in[0] = XY_W'(pos_x_ext);
         cz_in[0] = '0;
      end
      side_in[0].ok     = (mode_ff == tcp_pkg::MODE_FRONT) ||
                          (mode_ff == tcp_pkg::MODE_CYLINDRICAL);
      side_in[0].cyl    = (mode_ff == tcp_pkg::MODE_CYLINDRICAL);
      side_in[0].origin = (req_pos_x == '0) && (req_pos_y == '0);
      side_in[0].opnd_u = SUM_W'(req_pos_x) + SUM_W'(offset_x_ff);
      side_in[0].opnd_v = SUM_W'(req_pos_z) + SUM_W'(offset_y_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]   <= cx_in[0];
         cy_ff[0]   <= cy_in[0];
         cz_ff[0]   <= cz_in[0];
         side_ff[0] <= side_in[0];
      end
   end

   // One unrolled CORDIC step per stage, driven toward y = 0.
   for (genvar i = 1; i <= N_STEPS; i++) begin : g_step
      always_comb begin
         if (!cy_ff[i-1][XY_W-1]) begin
            cx_in[i] = cx_ff[i-1] + (cy_ff[i-1] >>> (i - 1));
            cy_in[i] = cy_ff[i-1] - (cx_ff[i-1] >>> (i - 1));
            cz_in[i] = cz_ff[i-1] +
                       Z_W'(tcp_pkg::atan_turn(tcp_pkg::ATAN_IDX_W'(i - 1)));
         end else begin
            cx_in[i] = cx_ff[i-1] - (cy_ff[i-1] >>> (i - 1));
            cy_in[i] = cy_ff[i-1] + (cx_ff[i-1] >>> (i - 1));
            cz_in[i] = cz_ff[i-1] -
                       Z_W'(tcp_pkg::atan_turn(tcp_pkg::ATAN_IDX_W'(i - 1)));
         end
         side_in[i] = side_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[i]   <= cx_in[i];
            cy_ff[i]   <= cy_in[i];
            cz_ff[i]   <= cz_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   // Angle stage: round the turn count to the fraction width and pick the u operand.
   always_comb begin
      z_rnd           = cz_ff[N_STEPS] + Z_RND;
      ang             = z_rnd >>> ZSH;
      side_in[ST_ANG] = side_ff[N_STEPS];
      if (side_ff[N_STEPS].cyl) begin
         side_in[ST_ANG].opnd_u = side_ff[N_STEPS].origin ? '0 : ang[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[ST_ANG] <= side_in[ST_ANG];
      end
   end

   // Multiply stage: exact signed products.
   always_comb begin
      prod_u_in = PROD_W'($signed(side_ff[ST_ANG].opnd_u)) * PROD_W'(scale_u_ff);
      prod_v_in = PROD_W'($signed(side_ff[ST_ANG].opnd_v)) * PROD_W'(scale_v_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_u_ff <= prod_u_in;
         prod_v_ff <= prod_v_in;
         ok_mul_ff <= side_ff[ST_ANG].ok;
      end
   end

   // Output stage: floor shift, v negated first, then saturate; unsupported modes give zeros.
   always_comb begin
      q_u      = SHIFT_W'(prod_u_ff) >>> FRAC_BITS;
      q_v      = (-SHIFT_W'(prod_v_ff)) >>> FRAC_BITS;
      tex_u_in = ok_mul_ff ? tcp_pkg::sat32(q_u) : '0;
      tex_v_in = ok_mul_ff ? tcp_pkg::sat32(q_v) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tex_u_ff  <= tex_u_in;
         tex_v_ff  <= tex_v_in;
         res_ok_ff <= ok_mul_ff;
      end
   end

   assign rsp_valid     = vld_ff[ST_OUT];
   assign rsp_tex_u     = tex_u_ff;
   assign rsp_tex_v     = tex_v_ff;
   assign rsp_valid_res = res_ok_ff;

   // Checks on the pipeline's own behavior.
   `TCPU_ASSERT_IMP(a_unsupported_zero, rsp_valid && !rsp_valid_res, (rsp_tex_u == '0) && (rsp_tex_v == '0), "unsupported mode result has nonzero coordinates")
   `TCPU_ASSERT_IMP(a_origin_angle, vld_ff[ST_ANG] && side_ff[ST_ANG].cyl && side_ff[ST_ANG].origin, side_ff[ST_ANG].opnd_u == '0, "origin in cylindrical mode gave a nonzero angle")
   `TCPU_ASSERT_IMP(a_stall_source, req_stall, rsp_valid && rsp_stall, "input stalled without a held result")
   `TCPU_ASSERT_NXT(a_reset_empty, reset, vld_ff == '0, "pipeline not empty after reset")

endmodule

`default_nettype wire

@@ bench/texture_coordinate_projector_unit_test.sv @@
// Self-checking testbench for texture_coordinate_projector_unit: front and cylindrical UV beats.
// Needs tcp_pkg and the top level; predicts the beats that are not typed in with its own fixed-point model.
`timescale 1ns / 1ps

module texture_coordinate_projector_unit_test;

   localparam int CLK_PERIOD     = 8;
   localparam int CORDIC_STEPS   = 16;
   localparam int FRAC_BITS      = 16;
   localparam int LATENCY        = CORDIC_STEPS + 4;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int HOLD_CYCLES    = 240;
   localparam int ROUNDS         = 6;
   localparam int ROUND_ITEMS    = 64;
   localparam int PRINT_LIMIT    = 40;
   localparam int TURN_DEPTH     = 30;

   // Unsupported projection modes and the register indexes that decode to nothing.
   localparam logic [1:0] MODE_NONE_2     = 2'd2;
   localparam logic [1:0] MODE_NONE_3     = 2'd3;
   localparam logic [2:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CSR_SPARE_LAST  = 3'd7;

   // Saturation bounds at the width of the exact product.
   localparam logic signed [79:0] PROD_HI = 80'sd2147483647;
   localparam logic signed [79:0] PROD_LO = -80'sd2147483648;

   // Arctangent of 2^-i as a fraction of a turn, in units of 2^-32 turn.
   localparam longint TURN_STEP [0:TURN_DEPTH-1] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1
   };

   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic               ok;
   } uv_result_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               typed;
      uv_result_type      want;
   } vertex_case_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_tex_u;
   logic signed [31:0] rsp_tex_v;
   logic               rsp_valid_res;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // Predictor copy of the registers, starting from their reset values.
   logic signed [31:0] cfg_offset_x = '0;
   logic signed [31:0] cfg_offset_y = '0;
   logic signed [31:0] cfg_scale_u  = 32'sh0001_0000;
   logic signed [31:0] cfg_scale_v  = 32'sh0001_0000;
   logic [1:0]         cfg_mode     = tcp_pkg::MODE_FRONT;

   uv_result_type uv_expect_q[$];
   int         failure_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_requests = 0;
   int         holds_taken   = 0;
   int         hold_left     = 0;

   // Directed vertices; the expected beat is typed in where it is obvious.
   vertex_case_type directed_rows [0:16] = '{
      '{tcp_pkg::MODE_FRONT, 32'sh0, 32'sh0, 32'sh0, 1'b1, '{32'sh0, 32'sh0, 1'b1}},
      '{tcp_pkg::MODE_FRONT, 32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 1'b1,
        '{32'sh7FFF_FFFF, 32'sh8000_0001, 1'b1}},
      '{tcp_pkg::MODE_FRONT, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1,
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1}},
      '{tcp_pkg::MODE_FRONT, 32'sh1, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1,
        '{32'sh1, 32'sh1, 1'b1}},
      '{tcp_pkg::MODE_FRONT, 32'shFFFF_FFFF, 32'sh8000_0000, 32'sh1, 1'b1,
        '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1}},
      '{tcp_pkg::MODE_FRONT, 32'sh0003_8000, 32'sh7FFF_FFFF, 32'shFFFE_4000, 1'b0, '0},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'sh0, 32'sh0, 32'sh0, 1'b1, '{32'sh0, 32'sh0, 1'b1}},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'sh0, 32'sh0, 32'sh0001_0000, 1'b1,
        '{32'sh0, 32'shFFFF_0000, 1'b1}},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'sh0, 32'sh0001_0000, 32'sh0, 1'b0, '0},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, '0},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 1'b0, '0},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'sh8000_0000, 32'sh8000_0000, 32'sh1, 1'b0, '0},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 1'b0, '0},
      '{tcp_pkg::MODE_CYLINDRICAL, 32'shFFFF_FFFF, 32'sh0001_0000, 32'sh0, 1'b0, '0},
      '{MODE_NONE_2, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1, '0},
      '{MODE_NONE_3, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, '0}
   };

   texture_coordinate_projector_unit #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .FRAC_BITS    (FRAC_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tex_u     (rsp_tex_u),
      .rsp_tex_v     (rsp_tex_v),
      .rsp_valid_res (rsp_valid_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Exact product, optionally negated, floored to the fraction and clamped to 32 bits.
   function automatic logic signed [31:0] scale_sat(input logic signed [33:0] a,
                                                    input logic signed [31:0] b,
                                                    input bit negate);
      logic signed [79:0] prod;
      logic signed [79:0] q;
      prod = a * b;
      if (negate) begin
         prod = -prod;
      end
      q = prod >>> FRAC_BITS;
      if (q > PROD_HI) begin
         return 32'sh7FFF_FFFF;
      end else if (q < PROD_LO) begin
         return 32'sh8000_0000;
      end
      return q[31:0];
   endfunction

   // atan2(ay, ax) in turns with FRAC_BITS fraction bits, by vectoring CORDIC.
   function automatic longint turn_angle(input longint ay, input longint ax);
      longint xs;
      longint ys;
      longint zs;
      longint dx;
      longint dy;
      xs = ax;
      ys = ay;
      zs = 0;
      if (xs == 0 && ys == 0) begin
         return 0;
      end
      // Fold the left half plane over by half a turn.
      if (xs < 0) begin
         zs = (ys >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         xs = -xs;
         ys = -ys;
      end
      for (int i = 0; i < CORDIC_STEPS && i < TURN_DEPTH; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys >= 0) begin
            xs += dx;
            ys -= dy;
            zs += TURN_STEP[i];
         end else begin
            xs -= dx;
            ys += dy;
            zs -= TURN_STEP[i];
         end
      end
      return (zs + (64'sd1 << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
   endfunction

   // Texture coordinates of one vertex under the current register settings.
   function automatic uv_result_type project_vertex(input logic signed [31:0] px,
                                                    input logic signed [31:0] py,
                                                    input logic signed [31:0] pz);
      uv_result_type      res;
      logic signed [33:0] opnd_u;
      logic signed [33:0] opnd_v;
      longint             ang;
      res = '0;
      if (cfg_mode == tcp_pkg::MODE_FRONT || cfg_mode == tcp_pkg::MODE_CYLINDRICAL) begin
         if (cfg_mode == tcp_pkg::MODE_FRONT) begin
            opnd_u = px + cfg_offset_x;
         end else begin
            ang = turn_angle(longint'(px), -longint'(py));
            opnd_u = ang[33:0];
         end
         opnd_v = pz + cfg_offset_y;
         res.u  = scale_sat(opnd_u, cfg_scale_u, 1'b0);
         res.v  = scale_sat(opnd_v, cfg_scale_v, 1'b1);
         res.ok = 1'b1;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] pick_coord();
      logic signed [31:0] val;
      case ($urandom_range(0, 15))
         0: val = 32'sh7FFF_FFFF;
         1: val = 32'sh8000_0000;
         2: val = '0;
         3: val = ($urandom_range(0, 1) != 0) ? 32'sd1 : -32'sd1;
         4, 5, 6, 7: val = int'($urandom_range(0, 2097152)) - 1048576;
         default: val = $urandom();
      endcase
      return val;
   endfunction

   function automatic logic [31:0] pick_reg_word();
      logic [31:0] val;
      case ($urandom_range(0, 9))
         0: val = 32'h7FFF_FFFF;
         1: val = 32'h8000_0000;
         2: val = '0;
         3: val = 32'h0001_0000;
         4: val = 32'hFFFF_0000;
         5, 6, 7: val = int'($urandom_range(0, 524288)) - 262144;
         default: val = $urandom();
      endcase
      return val;
   endfunction

   task automatic note_failure(input string msg);
      if (failure_count < PRINT_LIMIT) begin
         $display("%0t ns: %s", $time, msg);
      end
      failure_count++;
   endtask

   // Compare one accepted result beat against the oldest prediction.
   task automatic check_texcoord_beat();
      uv_result_type want;
      if (uv_expect_q.size() == 0) begin
         note_failure($sformatf("result beat with nothing expected: u %h v %h ok %b",
                                rsp_tex_u, rsp_tex_v, rsp_valid_res));
         return;
      end
      want = uv_expect_q.pop_front();
      if (rsp_tex_u !== want.u) begin
         note_failure($sformatf("tex_u got %h want %h", rsp_tex_u, want.u));
      end
      if (rsp_tex_v !== want.v) begin
         note_failure($sformatf("tex_v got %h want %h", rsp_tex_v, want.v));
      end
      if (rsp_valid_res !== want.ok) begin
         note_failure($sformatf("valid_res got %b want %b", rsp_valid_res, want.ok));
      end
   endtask

   // Result side: check beats, stall at random, and take long hold-offs on request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_texcoord_beat();
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_taken) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         holds_taken <= holds_taken + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Offer one vertex beat and record its prediction once it is taken.
   task automatic send_vertex(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz, input bit typed,
                              input uv_result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      do @(posedge clock); while (req_stall);
      uv_expect_q.push_back(typed ? want : project_vertex(px, py, pz));
   endtask

   // Write one register; the caller lowers csr_valid after the last write.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tcp_pkg::CSR_OFFSET_X: cfg_offset_x = data;
         tcp_pkg::CSR_OFFSET_Y: cfg_offset_y = data;
         tcp_pkg::CSR_SCALE_U:  cfg_scale_u  = data;
         tcp_pkg::CSR_SCALE_V:  cfg_scale_v  = data;
         tcp_pkg::CSR_MODE:     cfg_mode     = data[1:0];
         default: ;
      endcase
   endtask

   // Stop offering vertices and wait until every expected beat has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (uv_expect_q.size() != 0);
   endtask

   // Reprogram all registers between rounds; spare indexes must change nothing.
   task automatic program_regs(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] su, input logic [31:0] sv,
                               input logic [1:0] mode);
      wait_drain();
      write_csr(tcp_pkg::CSR_OFFSET_X, ox);
      write_csr(tcp_pkg::CSR_OFFSET_Y, oy);
      write_csr(tcp_pkg::CSR_SCALE_U, su);
      write_csr(tcp_pkg::CSR_SCALE_V, sv);
      write_csr(tcp_pkg::CSR_MODE, {30'($urandom()), mode});
      write_csr(3'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), $urandom());
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [1:0] mode;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 27;
      recv_idle_pct = 67;

      // Directed part: extremes and special cases, starting from reset settings.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].mode != cfg_mode) begin
            wait_drain();
            write_csr(tcp_pkg::CSR_MODE, {30'($urandom()), directed_rows[r].mode});
            csr_valid <= 1'b0;
         end
         send_vertex(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
                     directed_rows[r].typed, directed_rows[r].want);
      end

      // Random part: three idling patterns, several register settings in each.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 67 : 0;
         recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 27 : 0;
         for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            if (ph == 0 && rnd == 0) begin
               program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            tcp_pkg::MODE_FRONT);
            end else if (ph == 0 && rnd == 1) begin
               program_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            tcp_pkg::MODE_CYLINDRICAL);
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: mode = tcp_pkg::MODE_FRONT;
                  4, 5, 6, 7: mode = tcp_pkg::MODE_CYLINDRICAL;
                  8:          mode = MODE_NONE_2;
                  default:    mode = MODE_NONE_3;
               endcase
               program_regs(pick_reg_word(), pick_reg_word(), pick_reg_word(),
                            pick_reg_word(), mode);
            end
            for (int k = 0; k < ROUND_ITEMS; k++) begin
               // Early in the third round of each phase, hold the result side off so the pipeline backs up.
               if (rnd == 2 && k == 8) begin
                  hold_requests <= hold_requests + 1;
               end
               send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'b0, '0);
            end
         end
      end

      wait_drain();
      repeat (4 * LATENCY) @(posedge clock);
      if (uv_expect_q.size() != 0) begin
         note_failure($sformatf("%0d expected beats never arrived", uv_expect_q.size()));
      end
      if (failure_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

endmodule
